FILE: src/cie_pkg.sv
// Shared constants and types for the compressed instruction expander.
// Holds base opcodes, quadrant/funct3 selector codes and the result word type.
// No dependencies.
`default_nettype none

package cie_pkg;

    // Register width of the target; 64 or more selects the RV64C forms.
    localparam int XLEN_BITS = 32;
    localparam bit RV64      = (XLEN_BITS >= 64);

    // Base instruction opcodes.
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_IMM_32 = 7'h1B;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_LOAD_F = 7'h07;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_STOREF = 7'h27;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_REG_32 = 7'h3B;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_JALR   = 7'h67;

    // The one fixed word: ebreak.
    localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;

    // Fixed register numbers.
    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_RA   = 5'd1;
    localparam logic [4:0] REG_SP   = 5'd2;

    // Selector codes: quadrant in the upper two bits, funct3 in the lower three.
    localparam logic [4:0] SEL_ADDI4SPN = 5'b00_000;
    localparam logic [4:0] SEL_FLD      = 5'b00_001;
    localparam logic [4:0] SEL_LW       = 5'b00_010;
    localparam logic [4:0] SEL_FLW_LD   = 5'b00_011;
    localparam logic [4:0] SEL_FSD      = 5'b00_101;
    localparam logic [4:0] SEL_SW       = 5'b00_110;
    localparam logic [4:0] SEL_FSW_SD   = 5'b00_111;
    localparam logic [4:0] SEL_ADDI     = 5'b01_000;
    localparam logic [4:0] SEL_JAL_ADDIW = 5'b01_001;
    localparam logic [4:0] SEL_LI       = 5'b01_010;
    localparam logic [4:0] SEL_LUI_SP   = 5'b01_011;
    localparam logic [4:0] SEL_MISC_ALU = 5'b01_100;
    localparam logic [4:0] SEL_J        = 5'b01_101;
    localparam logic [4:0] SEL_BEQZ     = 5'b01_110;
    localparam logic [4:0] SEL_BNEZ     = 5'b01_111;
    localparam logic [4:0] SEL_SLLI     = 5'b10_000;
    localparam logic [4:0] SEL_FLDSP    = 5'b10_001;
    localparam logic [4:0] SEL_LWSP     = 5'b10_010;
    localparam logic [4:0] SEL_FLWSP_LDSP = 5'b10_011;
    localparam logic [4:0] SEL_JR_MV_ADD = 5'b10_100;
    localparam logic [4:0] SEL_FSDSP    = 5'b10_101;
    localparam logic [4:0] SEL_SWSP     = 5'b10_110;
    localparam logic [4:0] SEL_FSWSP_SDSP = 5'b10_111;

    // Sub-codes of the miscellaneous ALU group (bits 11:10).
    localparam logic [1:0] ALU_SRLI = 2'b00;
    localparam logic [1:0] ALU_SRAI = 2'b01;
    localparam logic [1:0] ALU_ANDI = 2'b10;
    localparam logic [1:0] ALU_REG  = 2'b11;

    // Register-register sub-codes (bits 6:5).
    localparam logic [1:0] CA_SUB = 2'b00;
    localparam logic [1:0] CA_XOR = 2'b01;
    localparam logic [1:0] CA_OR  = 2'b10;
    localparam logic [1:0] CA_AND = 2'b11;

    // One expanded result word.
    typedef struct packed {
        logic [31:0] word;
        logic        illegal;
    } cie_result_t;

endpackage

`default_nettype wire

FILE: src/cie_expand.sv
// Combinational expansion of one 16-bit compressed word into its 32-bit form.
// Depends on cie_pkg for opcodes, selector codes and the result type.
`default_nettype none

module cie_expand (
    input  wire logic [15:0]         compressed_word,
    output cie_pkg::cie_result_t     result
);

    logic [4:0]  sel;
    logic [4:0]  rdp;
    logic [4:0]  rs1p;
    logic [4:0]  rd;
    logic [4:0]  rs2;
    logic [11:0] wlsw;
    logic [11:0] dlsd;
    logic [5:0]  shamt;
    logic        shamt_bad;
    logic [11:0] imm6;
    logic [20:0] jimm;
    logic [12:0] bimm;
    logic [9:0]  addi4spn_imm;
    logic [9:0]  addi16sp_imm;
    logic [11:0] imm_fldsp;
    logic [11:0] imm_lwsp;
    logic [11:0] imm_fsdsp;
    logic [11:0] imm_swsp;
    logic [31:0] j_word;
    logic [31:0] b_word;
    logic [2:0]  ca_funct3;
    logic [6:0]  ca_funct7;
    logic [31:0] w;
    logic        ok;

    // Operand fields and immediates taken straight from the compressed word.
    always_comb
    begin
        sel       = {compressed_word[1:0], compressed_word[15:13]};
        rdp       = {2'b01, compressed_word[4:2]};
        rs1p      = {2'b01, compressed_word[9:7]};
        rd        = compressed_word[11:7];
        rs2       = compressed_word[6:2];
        wlsw      = {5'b0, compressed_word[5], compressed_word[12:10], compressed_word[6], 2'b0};
        dlsd      = {4'b0, compressed_word[6:5], compressed_word[12:10], 3'b0};
        shamt     = {compressed_word[12], compressed_word[6:2]};
        shamt_bad = !cie_pkg::RV64 && compressed_word[12];
        imm6      = {{7{compressed_word[12]}}, compressed_word[6:2]};
        jimm      = {{10{compressed_word[12]}}, compressed_word[8], compressed_word[10:9],
                     compressed_word[6], compressed_word[7], compressed_word[2],
                     compressed_word[11], compressed_word[5:3], 1'b0};
        bimm      = {{5{compressed_word[12]}}, compressed_word[6:5], compressed_word[2],
                     compressed_word[11:10], compressed_word[4:3], 1'b0};
        addi4spn_imm = {compressed_word[10:7], compressed_word[12:11], compressed_word[5],
                        compressed_word[6], 2'b0};
        addi16sp_imm = {compressed_word[12], compressed_word[4:3], compressed_word[5],
                        compressed_word[2], compressed_word[6], 4'b0};
        imm_fldsp = {3'b0, compressed_word[4:2], compressed_word[12], compressed_word[6:5], 3'b0};
        imm_lwsp  = {4'b0, compressed_word[3:2], compressed_word[12], compressed_word[6:4], 2'b0};
        imm_fsdsp = {3'b0, compressed_word[9:7], compressed_word[12:10], 3'b0};
        imm_swsp  = {4'b0, compressed_word[8:7], compressed_word[12:9], 2'b0};
    end

    // Jump and branch layouts; the jump's link register is chosen below.
    always_comb
    begin
        j_word = {jimm[20], jimm[10:1], jimm[11], jimm[19:12], cie_pkg::REG_ZERO,
                  cie_pkg::OP_JAL};
        b_word = {bimm[12], bimm[10:5], cie_pkg::REG_ZERO, rs1p, 3'b000, bimm[4:1], bimm[11],
                  cie_pkg::OP_BRANCH};
    end

    // Register-register group: subtract uses the alternate funct7.
    always_comb
    begin
        ca_funct7 = (compressed_word[6:5] == cie_pkg::CA_SUB) ? 7'h20 : 7'h00;
        case (compressed_word[6:5])
            cie_pkg::CA_SUB: ca_funct3 = 3'b000;
            cie_pkg::CA_XOR: ca_funct3 = 3'b100;
            cie_pkg::CA_OR:  ca_funct3 = 3'b110;
            cie_pkg::CA_AND: ca_funct3 = 3'b111;
            default:         ca_funct3 = 3'b000;
        endcase
    end

    // Main expansion by quadrant and funct3.
    always_comb
    begin
        w  = 32'h0;
        ok = 1'b1;
        case (sel)
            cie_pkg::SEL_ADDI4SPN:
            begin
                if (addi4spn_imm == 10'h0)
                    ok = 1'b0;
                else
                    w = {2'b0, addi4spn_imm, cie_pkg::REG_SP, 3'b000, rdp, cie_pkg::OP_IMM};
            end
            cie_pkg::SEL_FLD:
                w = {dlsd, rs1p, 3'b011, rdp, cie_pkg::OP_LOAD_F};
            cie_pkg::SEL_LW:
                w = {wlsw, rs1p, 3'b010, rdp, cie_pkg::OP_LOAD};
            cie_pkg::SEL_FLW_LD:
            begin
                if (cie_pkg::RV64)
                    w = {dlsd, rs1p, 3'b011, rdp, cie_pkg::OP_LOAD};
                else
                    w = {wlsw, rs1p, 3'b010, rdp, cie_pkg::OP_LOAD_F};
            end
            cie_pkg::SEL_FSD:
                w = {dlsd[11:5], rdp, rs1p, 3'b011, dlsd[4:0], cie_pkg::OP_STOREF};
            cie_pkg::SEL_SW:
                w = {wlsw[11:5], rdp, rs1p, 3'b010, wlsw[4:0], cie_pkg::OP_STORE};
            cie_pkg::SEL_FSW_SD:
            begin
                if (cie_pkg::RV64)
                    w = {dlsd[11:5], rdp, rs1p, 3'b011, dlsd[4:0], cie_pkg::OP_STORE};
                else
                    w = {wlsw[11:5], rdp, rs1p, 3'b010, wlsw[4:0], cie_pkg::OP_STOREF};
            end
            cie_pkg::SEL_ADDI:
                w = {imm6, rd, 3'b000, rd, cie_pkg::OP_IMM};
            cie_pkg::SEL_JAL_ADDIW:
            begin
                if (cie_pkg::RV64)
                begin
                    if (rd == cie_pkg::REG_ZERO)
                        ok = 1'b0;
                    else
                        w = {imm6, rd, 3'b000, rd, cie_pkg::OP_IMM_32};
                end
                else
                begin
                    w = {j_word[31:12], cie_pkg::REG_RA, j_word[6:0]};
                end
            end
            cie_pkg::SEL_LI:
                w = {imm6, cie_pkg::REG_ZERO, 3'b000, rd, cie_pkg::OP_IMM};
            cie_pkg::SEL_LUI_SP:
            begin
                if (rd == cie_pkg::REG_SP)
                begin
                    // Stack-pointer adjustment by a multiple of sixteen.
                    if (addi16sp_imm == 10'h0)
                        ok = 1'b0;
                    else
                        w = {{2{addi16sp_imm[9]}}, addi16sp_imm, cie_pkg::REG_SP, 3'b000,
                             cie_pkg::REG_SP, cie_pkg::OP_IMM};
                end
                else
                begin
                    if (shamt == 6'h0)
                        ok = 1'b0;
                    else
                        w = {{14{compressed_word[12]}}, compressed_word[12],
                             compressed_word[6:2], rd, cie_pkg::OP_LUI};
                end
            end
            cie_pkg::SEL_MISC_ALU:
            begin
                case (compressed_word[11:10])
                    cie_pkg::ALU_SRLI:
                    begin
                        if (shamt_bad)
                            ok = 1'b0;
                        else
                            w = {6'b0, shamt, rs1p, 3'b101, rs1p, cie_pkg::OP_IMM};
                    end
                    cie_pkg::ALU_SRAI:
                    begin
                        if (shamt_bad)
                            ok = 1'b0;
                        else
                            w = {6'b010000, shamt, rs1p, 3'b101, rs1p, cie_pkg::OP_IMM};
                    end
                    cie_pkg::ALU_ANDI:
                        w = {imm6, rs1p, 3'b111, rs1p, cie_pkg::OP_IMM};
                    default:
                    begin
                        if (!compressed_word[12])
                            w = {ca_funct7, rdp, rs1p, ca_funct3, rs1p, cie_pkg::OP_REG};
                        else if (cie_pkg::RV64 && !compressed_word[6])
                            w = {ca_funct7, rdp, rs1p, 3'b000, rs1p, cie_pkg::OP_REG_32};
                        else
                            ok = 1'b0;
                    end
                endcase
            end
            cie_pkg::SEL_J:
                w = j_word;
            cie_pkg::SEL_BEQZ:
                w = b_word;
            cie_pkg::SEL_BNEZ:
                w = {b_word[31:15], 3'b001, b_word[11:0]};
            cie_pkg::SEL_SLLI:
            begin
                if (shamt_bad)
                    ok = 1'b0;
                else
                    w = {6'b0, shamt, rd, 3'b001, rd, cie_pkg::OP_IMM};
            end
            cie_pkg::SEL_FLDSP:
                w = {imm_fldsp, cie_pkg::REG_SP, 3'b011, rd, cie_pkg::OP_LOAD_F};
            cie_pkg::SEL_LWSP:
            begin
                if (rd == cie_pkg::REG_ZERO)
                    ok = 1'b0;
                else
                    w = {imm_lwsp, cie_pkg::REG_SP, 3'b010, rd, cie_pkg::OP_LOAD};
            end
            cie_pkg::SEL_FLWSP_LDSP:
            begin
                if (cie_pkg::RV64)
                begin
                    if (rd == cie_pkg::REG_ZERO)
                        ok = 1'b0;
                    else
                        w = {imm_fldsp, cie_pkg::REG_SP, 3'b011, rd, cie_pkg::OP_LOAD};
                end
                else
                begin
                    w = {imm_lwsp, cie_pkg::REG_SP, 3'b010, rd, cie_pkg::OP_LOAD_F};
                end
            end
            cie_pkg::SEL_JR_MV_ADD:
            begin
                if (!compressed_word[12])
                begin
                    if (rs2 == cie_pkg::REG_ZERO)
                    begin
                        if (rd == cie_pkg::REG_ZERO)
                            ok = 1'b0;
                        else
                            w = {12'h0, rd, 3'b000, cie_pkg::REG_ZERO, cie_pkg::OP_JALR};
                    end
                    else
                    begin
                        w = {7'h00, rs2, cie_pkg::REG_ZERO, 3'b000, rd, cie_pkg::OP_REG};
                    end
                end
                else if (rs2 == cie_pkg::REG_ZERO)
                begin
                    if (rd == cie_pkg::REG_ZERO)
                        w = cie_pkg::EBREAK_WORD;
                    else
                        w = {12'h0, rd, 3'b000, cie_pkg::REG_RA, cie_pkg::OP_JALR};
                end
                else
                begin
                    w = {7'h00, rs2, rd, 3'b000, rd, cie_pkg::OP_REG};
                end
            end
            cie_pkg::SEL_FSDSP:
                w = {imm_fsdsp[11:5], rs2, cie_pkg::REG_SP, 3'b011, imm_fsdsp[4:0],
                     cie_pkg::OP_STOREF};
            cie_pkg::SEL_SWSP:
                w = {imm_swsp[11:5], rs2, cie_pkg::REG_SP, 3'b010, imm_swsp[4:0],
                     cie_pkg::OP_STORE};
            cie_pkg::SEL_FSWSP_SDSP:
            begin
                if (cie_pkg::RV64)
                    w = {imm_fsdsp[11:5], rs2, cie_pkg::REG_SP, 3'b011, imm_fsdsp[4:0],
                         cie_pkg::OP_STORE};
                else
                    w = {imm_swsp[11:5], rs2, cie_pkg::REG_SP, 3'b010, imm_swsp[4:0],
                         cie_pkg::OP_STOREF};
            end
            default:
                ok = 1'b0;
        endcase
    end

    // Illegal encodings give an all-zero word.
    assign result.word    = ok ? w : 32'h0;
    assign result.illegal = !ok;

endmodule

`default_nettype wire

FILE: src/cie_out_reg.sv
// Result register of the expander: holds one expanded word while the receiver stalls.
// Depends on cie_pkg for the result type.
`default_nettype none

module cie_out_reg (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire logic                 out_stall,
    input  wire cie_pkg::cie_result_t result_in,
    output logic                      out_valid,
    output cie_pkg::cie_result_t      result_out
);

    logic                 valid_reg;
    logic                 valid_next;
    cie_pkg::cie_result_t data_reg;

    // The word stays until taken; a new word may replace one that leaves this cycle.
    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (out_stall)
            valid_next = valid_reg;
        else
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload carries no reset.
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result_in;
    end

    assign out_valid  = valid_reg;
    assign result_out = data_reg;

endmodule

`default_nettype wire

FILE: src/compressed_instruction_expander.sv
// Top level of the compressed instruction expander: input register, expansion logic
// and result register. Depends on cie_pkg, cie_expand and cie_out_reg.
//
// Usage:
//   The input channel (in_valid, in_stall, compressed_word) takes one 16-bit
//   compressed instruction word per cycle while in_stall is low. The output
//   channel (out_valid, out_stall, expanded_word, is_illegal) returns one
//   32-bit word per input, in order. Reserved, unrecognised and uncompressed
//   encodings give a zero word with is_illegal set.
//   An accepted word waits in the input register, then the expansion logic
//   fills the result register from it.
//   Throughput is one word per cycle while out_stall is low, set by the single
//   pass of expansion logic between the two registers; the input register takes
//   a new word whenever the result register is free or is being emptied.
//   When the receiver stalls, the result register holds its word unchanged
//   and the input register keeps one more word; in_stall rises only when both
//   are full and out_stall is high.
//   Reset, asynchronous and active low, empties both registers; there is no
//   other state.
`default_nettype none

module compressed_instruction_expander (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] compressed_word,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      expanded_word,
    output logic             is_illegal
);

    logic                 word_valid_reg;
    logic                 word_valid_next;
    logic [15:0]          word_reg;
    logic                 in_take;
    logic                 out_load;
    cie_pkg::cie_result_t expanded;
    cie_pkg::cie_result_t result;

    // Handshake of the input register.
    assign out_load = word_valid_reg && (!out_valid || !out_stall);
    assign in_stall = word_valid_reg && out_valid && out_stall;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
            word_valid_next = 1'b1;
        else if (out_load)
            word_valid_next = 1'b0;
        else
            word_valid_next = word_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            word_valid_reg <= 1'b0;
        else
            word_valid_reg <= word_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            word_reg <= compressed_word;
    end

    // Expansion of the registered word.
    cie_expand u_expand (
        .compressed_word (word_reg),
        .result          (expanded)
    );

    // Result register towards the receiver.
    cie_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (out_load),
        .out_stall  (out_stall),
        .result_in  (expanded),
        .out_valid  (out_valid),
        .result_out (result)
    );

    assign expanded_word = result.word;
    assign is_illegal    = result.illegal;

endmodule

`default_nettype wire

FILE: src/cie_checker.sv
// Port-level checks of the compressed instruction expander, bound to its top level.
// Depends only on the top level's ports.
`default_nettype none

module cie_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic [15:0] compressed_word,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] expanded_word,
    input wire logic        is_illegal
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(expanded_word) && $stable(is_illegal))
        else $error("stalled result word changed");

    // An illegal result carries an all-zero word.
    a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_illegal |-> expanded_word == 32'h0)
        else $error("illegal result with nonzero word");

    // A legal result is always a full-length base instruction.
    a_legal_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_illegal |-> expanded_word[1:0] == 2'b11)
        else $error("legal result is not a 32-bit encoding");

    // The input side is held back only by a stalled receiver.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_stall && out_valid)
        else $error("input stalled without a stalled full result");

    // An uncompressed word accepted into an idle block comes out illegal from the result register.
    a_quadrant3: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && compressed_word[1:0] == 2'b11 && !out_valid ##1
        !out_valid |=> out_valid && is_illegal)
        else $error("uncompressed word not reported illegal");

endmodule

bind compressed_instruction_expander cie_checker u_cie_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .compressed_word (compressed_word),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .expanded_word   (expanded_word),
    .is_illegal      (is_illegal)
);

`default_nettype wire

FILE: test/tb_top.sv
// Testbench for compressed_instruction_expander: expands each 16-bit word in its own predictor
// and checks every result word and illegal flag, in order. Depends on cie_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import cie_pkg::*;

    // Base funct3 and funct7 values used when building the expanded words.
    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_SLL = 3'd1;
    localparam logic [2:0] F3_W   = 3'd2;
    localparam logic [2:0] F3_D   = 3'd3;
    localparam logic [2:0] F3_XOR = 3'd4;
    localparam logic [2:0] F3_SR  = 3'd5;
    localparam logic [2:0] F3_OR  = 3'd6;
    localparam logic [2:0] F3_AND = 3'd7;
    localparam logic [2:0] F3_BEQ = 3'd0;
    localparam logic [2:0] F3_BNE = 3'd1;
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam int RANDOM_WORDS = 550;
    localparam int DRAIN_MARK   = 300;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 20;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        logic [15:0] word;
        bit          after_drain;
    } send_item_t;

    typedef struct {
        logic [15:0] source;
        cie_result_t result;
    } expansion_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] compressed_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] expanded_word;
    logic        is_illegal;

    send_item_t words_to_send[$];
    expansion_t expansions_due[$];
    expansion_t due;

    int  src_gap = 0;
    int  snk_wait = 0;
    bit  src_idle_on = 1'b1;
    bit  snk_idle_on = 1'b1;
    int  words_sent = 0;
    int  results_seen = 0;
    int  illegal_seen = 0;
    int  mismatches = 0;
    int  cycle_count = 0;

    // Directed words: extremes of every offset field, reserved forms and the hint forms.
    logic [15:0] corner_words [0:29] = '{
        16'h0000, 16'hFFFF, 16'h1FFC, 16'h3FFC, 16'h5FFC, 16'h7FFC, 16'h9FFC, 16'hBFFC,
        16'hDFFC, 16'hFFFC, 16'h0005, 16'h3FFD, 16'h5FFD, 16'h6101, 16'h617D, 16'h6281,
        16'h72FD, 16'h9001, 16'h9401, 16'h9BFD, 16'h8C61, 16'h9C01, 16'hBFFD, 16'hDFFD,
        16'h1082, 16'h4002, 16'h8002, 16'h9002, 16'h908A, 16'hFFFE
    };

    compressed_instruction_expander dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .compressed_word (compressed_word),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .expanded_word   (expanded_word),
        .is_illegal      (is_illegal)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Base instruction formats.
    function automatic logic [31:0] pack_i(input logic [31:0] imm, input logic [4:0] rs1,
                                           input logic [2:0] f3, input logic [4:0] rd,
                                           input logic [6:0] op);
        return {imm[11:0], rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] pack_s(input logic [31:0] imm, input logic [4:0] rs2,
                                           input logic [4:0] rs1, input logic [2:0] f3,
                                           input logic [6:0] op);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], op};
    endfunction

    function automatic logic [31:0] pack_r(input logic [6:0] f7, input logic [4:0] rs2,
                                           input logic [4:0] rs1, input logic [2:0] f3,
                                           input logic [4:0] rd, input logic [6:0] op);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] pack_b(input logic [31:0] imm, input logic [4:0] rs1,
                                           input logic [2:0] f3);
        return {imm[12], imm[10:5], REG_ZERO, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
    endfunction

    function automatic logic [31:0] pack_j(input logic [31:0] imm, input logic [4:0] rd);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
    endfunction

    // Expands one compressed word into its base instruction and illegal flag.
    function automatic cie_result_t predict_expansion(input logic [15:0] c);
        cie_result_t r;
        logic [4:0]  sel;
        logic [4:0]  rd;
        logic [4:0]  rs2;
        logic [4:0]  rdp;
        logic [4:0]  rs1p;
        logic [5:0]  shamt;
        logic        shamt_wide;
        logic [31:0] imm;
        logic [31:0] wlsw;
        logic [31:0] dlsd;
        logic [31:0] simm6;
        logic [31:0] jimm;
        logic [31:0] bimm;
        logic [31:0] wsp_ld;
        logic [31:0] dsp_ld;
        logic [31:0] wsp_st;
        logic [31:0] dsp_st;
        logic [31:0] w;
        logic        ok;

        sel   = {c[1:0], c[15:13]};
        rd    = c[11:7];
        rs2   = c[6:2];
        rdp   = {2'b01, c[4:2]};
        rs1p  = {2'b01, c[9:7]};
        shamt = {c[12], c[6:2]};
        shamt_wide = !RV64 && c[12];

        // Immediate shapes of the various compressed formats.
        wlsw   = {25'd0, c[5], c[12:10], c[6], 2'b00};
        dlsd   = {24'd0, c[6:5], c[12:10], 3'b000};
        simm6  = {{26{c[12]}}, c[12], c[6:2]};
        jimm   = {{21{c[12]}}, c[8], c[10:9], c[6], c[7], c[2], c[11], c[5:3], 1'b0};
        bimm   = {{24{c[12]}}, c[6:5], c[2], c[11:10], c[4:3], 1'b0};
        wsp_ld = {24'd0, c[3:2], c[12], c[6:4], 2'b00};
        dsp_ld = {23'd0, c[4:2], c[12], c[6:5], 3'b000};
        wsp_st = {24'd0, c[8:7], c[12:9], 2'b00};
        dsp_st = {23'd0, c[9:7], c[12:10], 3'b000};

        ok = 1'b1;
        w  = '0;
        case (sel)
            SEL_ADDI4SPN:
            begin
                imm = {22'd0, c[10:7], c[12:11], c[5], c[6], 2'b00};
                if (imm == 0)
                    ok = 1'b0;
                else
                    w = pack_i(imm, REG_SP, F3_ADD, rdp, OP_IMM);
            end
            SEL_FLD: w = pack_i(dlsd, rs1p, F3_D, rdp, OP_LOAD_F);
            SEL_LW:  w = pack_i(wlsw, rs1p, F3_W, rdp, OP_LOAD);
            SEL_FLW_LD:
                w = RV64 ? pack_i(dlsd, rs1p, F3_D, rdp, OP_LOAD)
                         : pack_i(wlsw, rs1p, F3_W, rdp, OP_LOAD_F);
            SEL_FSD: w = pack_s(dlsd, rdp, rs1p, F3_D, OP_STOREF);
            SEL_SW:  w = pack_s(wlsw, rdp, rs1p, F3_W, OP_STORE);
            SEL_FSW_SD:
                w = RV64 ? pack_s(dlsd, rdp, rs1p, F3_D, OP_STORE)
                         : pack_s(wlsw, rdp, rs1p, F3_W, OP_STOREF);
            SEL_ADDI: w = pack_i(simm6, rd, F3_ADD, rd, OP_IMM);
            SEL_JAL_ADDIW:
            begin
                if (!RV64)
                    w = pack_j(jimm, REG_RA);
                else if (rd == REG_ZERO)
                    ok = 1'b0;
                else
                    w = pack_i(simm6, rd, F3_ADD, rd, OP_IMM_32);
            end
            SEL_LI: w = pack_i(simm6, REG_ZERO, F3_ADD, rd, OP_IMM);
            SEL_LUI_SP:
            begin
                if (rd == REG_SP)
                begin
                    imm = {{22{c[12]}}, c[12], c[4:3], c[5], c[2], c[6], 4'b0000};
                    if (imm == 0)
                        ok = 1'b0;
                    else
                        w = pack_i(imm, REG_SP, F3_ADD, REG_SP, OP_IMM);
                end
                else if (shamt == 0)
                    ok = 1'b0;
                else
                    w = {simm6[19:0], rd, OP_LUI};
            end
            SEL_MISC_ALU:
            begin
                case (c[11:10])
                    ALU_SRLI:
                    begin
                        if (shamt_wide)
                            ok = 1'b0;
                        else
                            w = pack_i({26'd0, shamt}, rs1p, F3_SR, rs1p, OP_IMM);
                    end
                    ALU_SRAI:
                    begin
                        if (shamt_wide)
                            ok = 1'b0;
                        else
                            w = pack_i({20'd0, 6'b010000, shamt}, rs1p, F3_SR, rs1p, OP_IMM);
                    end
                    ALU_ANDI: w = pack_i(simm6, rs1p, F3_AND, rs1p, OP_IMM);
                    default:
                    begin
                        if (!c[12])
                        begin
                            case (c[6:5])
                                CA_SUB: w = pack_r(F7_ALT, rdp, rs1p, F3_ADD, rs1p, OP_REG);
                                CA_XOR: w = pack_r(F7_BASE, rdp, rs1p, F3_XOR, rs1p, OP_REG);
                                CA_OR:  w = pack_r(F7_BASE, rdp, rs1p, F3_OR, rs1p, OP_REG);
                                default: w = pack_r(F7_BASE, rdp, rs1p, F3_AND, rs1p, OP_REG);
                            endcase
                        end
                        else if (RV64 && (c[6:5] == CA_SUB || c[6:5] == CA_XOR))
                            w = pack_r((c[6:5] == CA_SUB) ? F7_ALT : F7_BASE, rdp, rs1p,
                                       F3_ADD, rs1p, OP_REG_32);
                        else
                            ok = 1'b0;
                    end
                endcase
            end
            SEL_J:    w = pack_j(jimm, REG_ZERO);
            SEL_BEQZ: w = pack_b(bimm, rs1p, F3_BEQ);
            SEL_BNEZ: w = pack_b(bimm, rs1p, F3_BNE);
            SEL_SLLI:
            begin
                if (shamt_wide)
                    ok = 1'b0;
                else
                    w = pack_i({26'd0, shamt}, rd, F3_SLL, rd, OP_IMM);
            end
            SEL_FLDSP: w = pack_i(dsp_ld, REG_SP, F3_D, rd, OP_LOAD_F);
            SEL_LWSP:
            begin
                if (rd == REG_ZERO)
                    ok = 1'b0;
                else
                    w = pack_i(wsp_ld, REG_SP, F3_W, rd, OP_LOAD);
            end
            SEL_FLWSP_LDSP:
            begin
                if (!RV64)
                    w = pack_i(wsp_ld, REG_SP, F3_W, rd, OP_LOAD_F);
                else if (rd == REG_ZERO)
                    ok = 1'b0;
                else
                    w = pack_i(dsp_ld, REG_SP, F3_D, rd, OP_LOAD);
            end
            SEL_JR_MV_ADD:
            begin
                if (!c[12])
                begin
                    if (rs2 != REG_ZERO)
                        w = pack_r(F7_BASE, rs2, REG_ZERO, F3_ADD, rd, OP_REG);
                    else if (rd == REG_ZERO)
                        ok = 1'b0;
                    else
                        w = pack_i('0, rd, F3_ADD, REG_ZERO, OP_JALR);
                end
                else if (rs2 != REG_ZERO)
                    w = pack_r(F7_BASE, rs2, rd, F3_ADD, rd, OP_REG);
                else if (rd == REG_ZERO)
                    w = EBREAK_WORD;
                else
                    w = pack_i('0, rd, F3_ADD, REG_RA, OP_JALR);
            end
            SEL_FSDSP: w = pack_s(dsp_st, rs2, REG_SP, F3_D, OP_STOREF);
            SEL_SWSP:  w = pack_s(wsp_st, rs2, REG_SP, F3_W, OP_STORE);
            SEL_FSWSP_SDSP:
                w = RV64 ? pack_s(dsp_st, rs2, REG_SP, F3_D, OP_STORE)
                         : pack_s(wsp_st, rs2, REG_SP, F3_W, OP_STOREF);
            default: ok = 1'b0;
        endcase

        r.word    = ok ? w : '0;
        r.illegal = !ok;
        return r;
    endfunction

    // Input driver: offers queued words, records the expansion of each accepted word.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid        <= 1'b0;
            compressed_word <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expansions_due.push_back('{compressed_word, predict_expansion(compressed_word)});
                words_to_send.delete(0);
                words_sent++;
                src_gap = src_idle_on ? $urandom_range(0, 14) : 0;
                if ($urandom_range(0, 49) == 0)
                    src_idle_on = !src_idle_on;
            end
            // A stalled word stays put; otherwise pick the next word or idle.
            if (!in_valid || !in_stall)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    in_valid <= 1'b0;
                end
                else if (words_to_send.size() != 0 &&
                         !(words_to_send[0].after_drain && expansions_due.size() != 0))
                begin
                    in_valid        <= 1'b1;
                    compressed_word <= words_to_send[0].word;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: checks each accepted result word and draws the next stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expansions_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result word %h, illegal %0b", expanded_word,
                                 is_illegal);
                end
                else
                begin
                    due = expansions_due.pop_front();
                    if (due.result.illegal)
                        illegal_seen++;
                    if (expanded_word !== due.result.word || is_illegal !== due.result.illegal)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch for %h: expected %h illegal %0b, got %h illegal %0b",
                                     due.source, due.result.word, due.result.illegal,
                                     expanded_word, is_illegal);
                    end
                end
                snk_wait = snk_idle_on ? $urandom_range(0, 14) : 0;
                // Two long hold-offs let the block fill up and stall its input.
                if (results_seen == 150 || results_seen == 420)
                    snk_wait = LONG_HOLD;
                if ($urandom_range(0, 49) == 0)
                    snk_idle_on = !snk_idle_on;
            end
            if (snk_wait > 0)
            begin
                snk_wait--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run timed out after %0d cycles", cycle_count);
        $display("FAIL compressed_instruction_expander");
        $finish;
    end

    // Stimulus: directed corner words, then shaped random words, then the end of run.
    initial
    begin
        send_item_t  item;
        logic [15:0] w;

        foreach (corner_words[i])
        begin
            item.word        = corner_words[i];
            item.after_drain = 1'b0;
            words_to_send.push_back(item);
        end
        // Mostly compressed words; zeroed immediates and rd of zero or sp reach the special forms.
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            w = 16'($urandom_range(0, 16'hFFFF));
            if ($urandom_range(0, 7) != 0)
                w[1:0] = 2'($urandom_range(0, 2));
            if ($urandom_range(0, 5) == 0)
            begin
                w[12]  = 1'b0;
                w[6:2] = 5'd0;
            end
            if ($urandom_range(0, 5) == 0)
                w[11:7] = ($urandom_range(0, 1) != 0) ? REG_SP : REG_ZERO;
            item.word        = w;
            item.after_drain = (i == 0 || i == DRAIN_MARK);
            words_to_send.push_back(item);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (words_to_send.size() != 0 || in_valid)
            @(posedge clk);
        while (expansions_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d words (%0d directed, %0d random) and checked %0d results, %0d illegal.",
                 words_sent, $size(corner_words), RANDOM_WORDS, results_seen, illegal_seen);
        $display("Random idling on both sides, two long output hold-offs, %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && expansions_due.size() == 0)
            $display("PASS compressed_instruction_expander");
        else
            $display("FAIL compressed_instruction_expander");
        $finish;
    end

endmodule
